// ===== sv/ate_pkg.sv =====
// Shared types and constants for the autocorrelation tempo estimator.
package ate_pkg;

  localparam int unsigned ONSET_W   = 16;
  localparam int unsigned RATE_W    = 18;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

  // lag bounds: max lag = rate >> 9, min lag = (rate >> 9) / 3
  localparam int unsigned HOP_SHIFT  = 9;
  localparam int unsigned QL_W       = RATE_W - HOP_SHIFT;
  localparam logic [7:0]  DIV3_MUL   = 8'd171;   // 171/512 ~ 1/3, exact below 512
  localparam int unsigned DIV3_SHIFT = 9;
  localparam int unsigned MINL_W     = 8;
  localparam int unsigned LAG_W      = 10;

  // tempo = floor((150*rate + 64*lag) / (128*lag))
  localparam int unsigned NUM_W     = 26;
  localparam int unsigned TEMPO_MUL = 150;
  localparam int unsigned LAG_SHIFT = 6;
  localparam int unsigned DEN_SHIFT = 7;
  localparam int unsigned QUO_W     = NUM_W - DEN_SHIFT;
  localparam int unsigned BPM_W     = 12;
  localparam logic [BPM_W-1:0] BPM_MAX = 12'd4095;

  typedef struct packed {
    logic [ONSET_W-1:0] onset_value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [BPM_W-1:0] bpm_tenths;
    logic [11:0]      peak_lag;
    logic             peak_found;
    logic             truncated;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic calc_range;
    logic bounds;
    logic sum_start;
    logic eval;
    logic tempo;
    logic div_start;
    logic result;
  } ate_cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic empty;
    logic last_lag;
    logic div_busy;
    logic out_full;
  } ate_status_t;

endpackage

// ===== sv/ate_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module ate_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== sv/ate_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ate_div
  import ate_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QUO_W-1:0] dividend_i,
  input  logic [LAG_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(QUO_W);

  logic             busy_q;
  logic [CW-1:0]    cnt_q;
  logic [LAG_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [LAG_W:0]   trial;
  logic             ge;
  logic [LAG_W:0]   rem_d;

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign rem_d = ge ? (trial - {1'b0, divisor_i}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QUO_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d[LAG_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/ate_ctrl.sv =====
// Sequencer for load, lag sweep, peak pick and tempo division.
module ate_ctrl
  import ate_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_last_i,
  output logic        in_stall_o,
  input  ate_status_t status_i,
  output ate_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_LOAD, S_RANGE, S_BOUNDS, S_START, S_SUM,
    S_EVAL, S_TEMPO, S_DSTART, S_DIV, S_OUT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      unique case (state_q)
        S_LOAD:   if (in_valid_i && in_last_i) state_q <= S_RANGE;
        S_RANGE:  state_q <= S_BOUNDS;
        S_BOUNDS: state_q <= status_i.empty ? S_TEMPO : S_START;
        S_START:  state_q <= S_SUM;
        S_SUM:    if (!status_i.mac_busy) state_q <= S_EVAL;
        S_EVAL:   state_q <= status_i.last_lag ? S_TEMPO : S_START;
        S_TEMPO:  state_q <= S_DSTART;
        S_DSTART: state_q <= S_DIV;
        S_DIV:    if (!status_i.div_busy) state_q <= S_OUT;
        S_OUT:    if (!status_i.out_full) state_q <= S_LOAD;
        default:  state_q <= S_LOAD;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_LOAD);

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == S_LOAD) && in_valid_i;
    cmd_o.calc_range = (state_q == S_RANGE);
    cmd_o.bounds     = (state_q == S_BOUNDS);
    cmd_o.sum_start  = (state_q == S_START);
    cmd_o.eval       = (state_q == S_EVAL);
    cmd_o.tempo      = (state_q == S_TEMPO);
    cmd_o.div_start  = (state_q == S_DSTART);
    cmd_o.result     = (state_q == S_OUT) && !status_i.out_full;
  end

endmodule

// ===== sv/ate_dp.sv =====
// Datapath: onset store, MAC pipeline, peak tracking, tempo and result register.
module ate_dp
  import ate_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 4096,
  parameter int unsigned ONSET_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ate_cmd_t          cmd_i,
  output ate_status_t       status_o,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_data_i,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  localparam int unsigned SW     = (ONSET_BITS < ONSET_W) ? ONSET_BITS : ONSET_W;
  localparam int unsigned ADDR_W = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CMP_W  = (CNT_W > LAG_W) ? CNT_W : LAG_W;
  localparam int unsigned PROD_W = 2 * SW;
  localparam int unsigned ACC_W  = PROD_W + ADDR_W;
  localparam int unsigned MP_W   = QL_W + 8;

  // control state
  logic [RATE_W-1:0] rate_q;
  logic [CNT_W-1:0]  frame_count_q;
  logic              overflow_q;
  logic              issuing_q, v1_q, v2_q;
  logic              out_valid_q;

  // payload
  logic [QL_W-1:0]   maxraw_q;
  logic [MINL_W-1:0] minl_q;
  logic [LAG_W-1:0]  lo_q, hi_q, lag_q, best_lag_q;
  logic [ADDR_W-1:0] i_q, j_q;
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc_q, prev_q, cur_q, best_q;
  logic              found_q;
  logic [NUM_W-1:0]  num_q;
  out_item_t         out_q;

  logic [SW-1:0]     rd_a, rd_b;
  logic              store_full, ram_we;
  logic [ADDR_W-1:0] n_last;
  logic [MP_W-1:0]   min_prod;
  logic [CMP_W-1:0]  n_ext, maxr_ext, n_m2, hi_ext;
  logic [LAG_W-1:0]  lo_c;
  logic              empty_c, take_c;
  logic              div_busy;
  logic [QUO_W-1:0]  quo;
  logic [BPM_W-1:0]  bpm_c;

  assign store_full = (frame_count_q == CNT_W'(MAX_FRAMES));
  assign ram_we     = cmd_i.load && !store_full;
  assign n_last     = ADDR_W'(frame_count_q - CNT_W'(1));

  ate_ram #(.WIDTH(SW), .DEPTH(MAX_FRAMES)) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (frame_count_q[ADDR_W-1:0]),
    .wdata_i   (in_data_i.onset_value[SW-1:0]),
    .raddr_a_i (i_q),
    .raddr_b_i (j_q),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // min lag: (rate >> 9) / 3 by reciprocal multiply
  assign min_prod = MP_W'(rate_q[RATE_W-1:HOP_SHIFT]) * DIV3_MUL;

  // lag window bounds
  assign n_ext    = CMP_W'(frame_count_q);
  assign maxr_ext = CMP_W'(maxraw_q);
  assign n_m2     = n_ext - CMP_W'(2);
  assign hi_ext   = (maxr_ext < n_m2) ? maxr_ext : n_m2;
  assign lo_c     = (minl_q == '0) ? LAG_W'(1) : LAG_W'(minl_q);
  assign empty_c  = (n_ext < CMP_W'(3)) || (CMP_W'(lo_c) > hi_ext);

  // candidate lag_q-1 against its neighbors, acc_q holds A(lag_q)
  assign take_c = (lag_q > lo_q) && (cur_q > best_q) && (cur_q > prev_q)
                  && (cur_q > acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q        <= RATE_RESET;
      frame_count_q <= '0;
      overflow_q    <= 1'b0;
      issuing_q     <= 1'b0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        if (store_full) begin
          overflow_q <= 1'b1;
        end else begin
          frame_count_q <= frame_count_q + CNT_W'(1);
        end
      end
      if (cmd_i.sum_start) begin
        issuing_q <= 1'b1;
      end else if (issuing_q && (j_q == n_last)) begin
        issuing_q <= 1'b0;
      end
      v1_q <= issuing_q;
      v2_q <= v1_q;
      if (cmd_i.result) begin
        out_valid_q   <= 1'b1;
        frame_count_q <= '0;
        overflow_q    <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_range) begin
      maxraw_q <= rate_q[RATE_W-1:HOP_SHIFT];
      // min lag is registered one step ahead of the bounds step
      minl_q   <= MINL_W'(min_prod >> DIV3_SHIFT);
    end
    if (cmd_i.bounds) begin
      lo_q       <= lo_c;
      hi_q       <= LAG_W'(hi_ext);
      lag_q      <= lo_c - LAG_W'(1);
      best_q     <= '0;
      best_lag_q <= LAG_W'(minl_q);
      found_q    <= 1'b0;
    end
    if (cmd_i.sum_start) begin
      i_q   <= '0;
      j_q   <= ADDR_W'(lag_q);
      acc_q <= '0;
    end else begin
      if (issuing_q) begin
        i_q <= i_q + ADDR_W'(1);
        j_q <= j_q + ADDR_W'(1);
      end
      if (v2_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
    if (v1_q) begin
      prod_q <= rd_a * rd_b;
    end
    if (cmd_i.eval) begin
      if (take_c) begin
        best_q     <= cur_q;
        best_lag_q <= lag_q - LAG_W'(1);
        found_q    <= 1'b1;
      end
      prev_q <= cur_q;
      cur_q  <= acc_q;
      lag_q  <= lag_q + LAG_W'(1);
    end
    if (cmd_i.tempo) begin
      num_q <= NUM_W'(rate_q) * NUM_W'(TEMPO_MUL)
               + (NUM_W'(best_lag_q) << LAG_SHIFT);
    end
    if (cmd_i.result) begin
      out_q.bpm_tenths <= bpm_c;
      out_q.peak_lag   <= 12'(best_lag_q);
      out_q.peak_found <= found_q;
      out_q.truncated  <= overflow_q;
    end
  end

  ate_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q[NUM_W-1:DEN_SHIFT]),
    .divisor_i  (best_lag_q),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign bpm_c = ((best_lag_q == '0) || (quo[QUO_W-1:BPM_W] != '0)) ? BPM_MAX
                 : quo[BPM_W-1:0];

  assign status_o.mac_busy = issuing_q || v1_q || v2_q;
  assign status_o.empty    = empty_c;
  assign status_o.last_lag = (lag_q == hi_q + LAG_W'(1));
  assign status_o.div_busy = div_busy;
  assign status_o.out_full = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/autocorrelation_tempo_estimator_top.sv =====
// Top level of the autocorrelation tempo estimator.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o  | in_item_t  (onset_value, last)
//  out     | output    | out_valid_o / out_stall_i| out_item_t (bpm_tenths, peak_lag,
//          |           |                        |   peak_found, truncated)
//  cfg     | input     | cfg_we_i, no wait      | sample_rate, 18 bits
//
// Loading accepts one transfer per cycle. After a transfer with last set the
// input stalls while the lag sweep runs: each lag L from max(minLag,1)-1 to
// hi+1 is summed as (n - L) products on the shared MAC; besides the sweep come
// the range and bounds steps, the tempo multiply, a wait on the 19-step
// division and the result step. The onset store's two read ports set the
// one-product-per-cycle MAC rate.
// The result sits in an output register, so loading of the next sequence
// resumes while it waits to be taken; a second result waits for it to drain.
// Reset clears the count, the overflow flag and sets sample_rate to 44100;
// the onset store is not cleared and needs no clearing pass.
module autocorrelation_tempo_estimator_top
  import ate_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 4096,
  parameter int unsigned ONSET_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_data_i
);

  ate_cmd_t    cmd;
  ate_status_t status;

  // sequencer: one item at a time through load, sweep and division
  ate_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // store, MAC, peak pick, divider and result register
  ate_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .ONSET_BITS (ONSET_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/ate_checker.sv =====
// Port-level checker for the tempo estimator, bound to the top level.
module ate_checker
  import ate_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input in_item_t          in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input out_item_t         out_data_o,
  input logic              cfg_we_i,
  input logic [RATE_W-1:0] cfg_data_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  // the input is stalled right after the closing transfer
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last |=> in_stall_o)
    else $error("input not stalled after last transfer");

  // a real peak never sits at lag zero
  a_peak_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.peak_found |-> out_data_o.peak_lag != 12'd0)
    else $error("peak reported at lag zero");

  // lag zero saturates the tempo
  a_zero_lag_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.peak_lag == 12'd0 |-> out_data_o.bpm_tenths == BPM_MAX)
    else $error("lag zero without saturated tempo");

  // lags never exceed the largest rate-derived bound
  a_lag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.peak_lag < 12'd512)
    else $error("peak lag out of range");

endmodule

bind autocorrelation_tempo_estimator_top ate_checker u_ate_checker (.*);
